### rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg: shared types and constants of the congestion window unit
// Phase codes, state and result records, configuration register indexes and
// the saturating helper used by the update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package rcw_pkg;

  // Window width and saturation limit
  localparam int unsigned WinBits = 16;
  localparam logic [WinBits-1:0] WinMax = {WinBits{1'b1}};

  // Field widths fixed by the interface
  localparam int unsigned AckBits = 32;
  localparam int unsigned DupBits = 4;
  localparam int unsigned AvdBits = 2;

  localparam logic [DupBits-1:0] DupMax = {DupBits{1'b1}};

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] CfgDupThreshold = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgInitRwnd     = 1'b1;

  // Reset values of the configuration registers
  localparam logic [DupBits-1:0] DupThresholdRst = 4'd3;
  localparam logic [WinBits-1:0] InitRwndRst     = 16'd16;

  // Event codes
  localparam logic OpAck     = 1'b0;
  localparam logic OpTimeout = 1'b1;

  typedef enum logic [1:0] {
    PhSlowStart = 2'd0,
    PhAvoidance = 2'd1,
    PhRecovery  = 2'd2
  } phase_e;

  // Connection state
  typedef struct packed {
    phase_e              phase;
    logic [WinBits-1:0]  cwnd;
    logic [WinBits-1:0]  ssthresh;
    logic [DupBits-1:0]  dup_cnt;
    logic [AvdBits-1:0]  avd_cnt;
    logic [AckBits-1:0]  prev_ack;
    logic [WinBits-1:0]  rwnd;
  } state_t;

  // One result item
  typedef struct packed {
    logic [WinBits-1:0] cwnd_out;
    logic [WinBits-1:0] ssthresh_out;
    logic [1:0]         phase_out;
    logic [WinBits-1:0] send_allowance;
    logic               retransmit;
    logic               zero_win_probe;
  } result_t;

  // Saturating add of a small constant
  function automatic logic [WinBits-1:0] sat_add(input logic [WinBits-1:0] a,
                                                 input logic [1:0] b);
    logic [WinBits:0] sum;
    sum = {1'b0, a} + {{(WinBits-1){1'b0}}, b};
    return sum[WinBits] ? WinMax : sum[WinBits-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/rcw_if.sv
// ----------------------------------------------------------------------------
// rcw_evt_if / rcw_res_if: valid/ready channels of the congestion window unit
// Event channel carries ACKs and timeouts, result channel the window values.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcw_evt_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [rcw_pkg::AckBits-1:0]     ack_number;
  logic [rcw_pkg::WinBits-1:0]     advertised_window;

  modport source (output valid, op, ack_number, advertised_window, input ready);
  modport sink   (input valid, op, ack_number, advertised_window, output ready);
endinterface

interface rcw_res_if;
  logic                            valid;
  logic                            ready;
  logic [rcw_pkg::WinBits-1:0]     cwnd_out;
  logic [rcw_pkg::WinBits-1:0]     ssthresh_out;
  logic [1:0]                      phase_out;
  logic [rcw_pkg::WinBits-1:0]     send_allowance;
  logic                            retransmit;
  logic                            zero_win_probe;

  modport source (output valid, cwnd_out, ssthresh_out, phase_out, send_allowance,
                  retransmit, zero_win_probe, input ready);
  modport sink   (input valid, cwnd_out, ssthresh_out, phase_out, send_allowance,
                  retransmit, zero_win_probe, output ready);
endinterface

`default_nettype wire

### rtl/rcw_update.sv
// ----------------------------------------------------------------------------
// rcw_update: next-state logic for one ACK or timeout event
// Computes the Reno phase, window, threshold and counters after the event,
// plus the retransmit and probe requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rcw_update (
  input  rcw_pkg::state_t                state_i,
  input  logic [rcw_pkg::DupBits-1:0]    dup_threshold_i,
  input  logic                           op_i,
  input  logic [rcw_pkg::AckBits-1:0]    ack_number_i,
  input  logic [rcw_pkg::WinBits-1:0]    advertised_window_i,
  output rcw_pkg::state_t                state_o,
  output rcw_pkg::result_t               result_o
);

  rcw_pkg::state_t                nxt;
  logic                           is_new;
  logic [rcw_pkg::WinBits-1:0]    cwnd_inc;
  logic [rcw_pkg::WinBits-1:0]    half_thr;
  logic                           rtx;
  logic                           probe;

  // Shared terms
  assign is_new   = (state_i.prev_ack == '0) || (state_i.prev_ack != ack_number_i);
  assign cwnd_inc = rcw_pkg::sat_add(state_i.cwnd, 2'd1);
  assign half_thr = rcw_pkg::sat_add({1'b0, state_i.cwnd[rcw_pkg::WinBits-1:1]}, 2'd1);

  // Event handling
  always_comb begin
    nxt   = state_i;
    rtx   = 1'b0;
    probe = 1'b0;
    if (op_i == rcw_pkg::OpTimeout) begin
      if (state_i.rwnd != '0) begin
        nxt.ssthresh = half_thr;
        nxt.cwnd     = {{(rcw_pkg::WinBits-1){1'b0}}, 1'b1};
        nxt.phase    = rcw_pkg::PhSlowStart;
        nxt.dup_cnt  = '0;
        nxt.avd_cnt  = '0;
        rtx          = 1'b1;
      end else begin
        probe = 1'b1;
      end
    end else if (is_new) begin
      case (state_i.phase)
        rcw_pkg::PhAvoidance: begin
          if (state_i.avd_cnt >= 2'd2) begin
            nxt.cwnd    = cwnd_inc;
            nxt.avd_cnt = '0;
          end else begin
            nxt.avd_cnt = state_i.avd_cnt + 2'd1;
          end
        end
        rcw_pkg::PhRecovery: begin
          nxt.cwnd    = state_i.ssthresh;
          nxt.phase   = rcw_pkg::PhAvoidance;
          nxt.avd_cnt = '0;
        end
        default: begin
          // slow start, and the unused phase code
          nxt.cwnd = cwnd_inc;
          if (cwnd_inc >= state_i.ssthresh) begin
            nxt.phase   = rcw_pkg::PhAvoidance;
            nxt.avd_cnt = '0;
          end
        end
      endcase
      nxt.dup_cnt  = '0;
      nxt.prev_ack = ack_number_i;
      nxt.rwnd     = advertised_window_i;
    end else if (state_i.dup_cnt >= dup_threshold_i) begin
      // fast retransmit; receiver window kept
      if (state_i.phase != rcw_pkg::PhRecovery) begin
        nxt.ssthresh = half_thr;
        nxt.cwnd     = rcw_pkg::sat_add(half_thr, 2'd3);
        nxt.phase    = rcw_pkg::PhRecovery;
        nxt.dup_cnt  = '0;
        nxt.avd_cnt  = '0;
      end
      rtx = (state_i.rwnd != '0);
    end else begin
      // duplicate below threshold
      if (state_i.phase == rcw_pkg::PhRecovery) begin
        nxt.cwnd = cwnd_inc;
      end else if (state_i.dup_cnt != rcw_pkg::DupMax) begin
        nxt.dup_cnt = state_i.dup_cnt + 4'd1;
      end
      nxt.avd_cnt = '0;
      nxt.rwnd    = advertised_window_i;
    end
  end

  // Result item
  always_comb begin
    result_o.cwnd_out       = nxt.cwnd;
    result_o.ssthresh_out   = nxt.ssthresh;
    result_o.phase_out      = nxt.phase;
    result_o.send_allowance = (nxt.rwnd < nxt.cwnd) ? nxt.rwnd : nxt.cwnd;
    result_o.retransmit     = rtx;
    result_o.zero_win_probe = probe;
  end

  assign state_o = nxt;

endmodule

`default_nettype wire

### rtl/reno_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// reno_congestion_window_unit: Reno-style sender congestion window engine
// Takes ACK and timeout events and returns the updated window state.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the state updates as the
//   result register loads. Throughput: one event per cycle while the result
//   channel is not stalled; the state update loop sets it.
// Reset: phase slow start, cwnd 1, ssthresh 8, receiver window 16,
//   duplicate threshold 3, counters and last ACK zero, both stages empty.
`default_nettype none

module reno_congestion_window_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rcw_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rcw_pkg::WinBits-1:0]       cfg_wdata_i,
  rcw_evt_if.sink                           evt_i,
  rcw_res_if.source                         res_o
);

  // Input stage
  logic                            in_vld_q;
  logic                            in_op_q;
  logic [rcw_pkg::AckBits-1:0]     in_ack_q;
  logic [rcw_pkg::WinBits-1:0]     in_adv_q;

  // Result stage
  logic                            out_vld_q;
  rcw_pkg::result_t                out_q;

  // State
  rcw_pkg::state_t                 state_q;
  rcw_pkg::state_t                 state_d;
  logic [rcw_pkg::DupBits-1:0]     dup_thr_q;

  rcw_pkg::state_t                 upd_state;
  rcw_pkg::result_t                upd_result;
  logic                            advance;
  logic                            in_take;

  // Handshake
  assign advance   = in_vld_q && (!out_vld_q || res_o.ready);
  assign in_take   = evt_i.valid && evt_i.ready;
  assign evt_i.ready = !in_vld_q || advance;

  rcw_update u_update (
    .state_i             (state_q),
    .dup_threshold_i     (dup_thr_q),
    .op_i                (in_op_q),
    .ack_number_i        (in_ack_q),
    .advertised_window_i (in_adv_q),
    .state_o             (upd_state),
    .result_o            (upd_result)
  );

  // Next state: item update, then configuration loads
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = upd_state;
    end
    if (cfg_we_i && (cfg_idx_i == rcw_pkg::CfgInitRwnd)) begin
      state_d.rwnd     = cfg_wdata_i;
      state_d.ssthresh = {1'b0, cfg_wdata_i[rcw_pkg::WinBits-1:1]};
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q          <= 1'b0;
      out_vld_q         <= 1'b0;
      dup_thr_q         <= rcw_pkg::DupThresholdRst;
      state_q.phase     <= rcw_pkg::PhSlowStart;
      state_q.cwnd      <= {{(rcw_pkg::WinBits-1){1'b0}}, 1'b1};
      state_q.ssthresh  <= {1'b0, rcw_pkg::InitRwndRst[rcw_pkg::WinBits-1:1]};
      state_q.dup_cnt   <= '0;
      state_q.avd_cnt   <= '0;
      state_q.prev_ack  <= '0;
      state_q.rwnd      <= rcw_pkg::InitRwndRst;
    end else begin
      state_q <= state_d;
      if (evt_i.ready) begin
        in_vld_q <= evt_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_i == rcw_pkg::CfgDupThreshold)) begin
        dup_thr_q <= cfg_wdata_i[rcw_pkg::DupBits-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q  <= evt_i.op;
      in_ack_q <= evt_i.ack_number;
      in_adv_q <= evt_i.advertised_window;
    end
    if (advance) begin
      out_q <= upd_result;
    end
  end

  // Result channel
  assign res_o.valid          = out_vld_q;
  assign res_o.cwnd_out       = out_q.cwnd_out;
  assign res_o.ssthresh_out   = out_q.ssthresh_out;
  assign res_o.phase_out      = out_q.phase_out;
  assign res_o.send_allowance = out_q.send_allowance;
  assign res_o.retransmit     = out_q.retransmit;
  assign res_o.zero_win_probe = out_q.zero_win_probe;

endmodule

`default_nettype wire

### test/tb_reno_congestion_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reno_congestion_window_unit: self-checking bench of the congestion unit
// Streams ACK and timeout events through the event channel, predicts every
// result with a local Reno window model and compares each field of the
// result channel in order. Both channels idle at random, and the receiver
// holds off for long stretches so the unit backs up. The run steps through
// several duplicate thresholds and initial receiver windows.
// ----------------------------------------------------------------------------

module tb_reno_congestion_window_unit;

  // One event item as queued for the driver
  typedef struct packed {
    logic                        op;
    logic [rcw_pkg::AckBits-1:0] ack;
    logic [rcw_pkg::WinBits-1:0] adv;
  } evt_item_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [rcw_pkg::CfgIdxBits-1:0] cfg_idx_i;
  logic [rcw_pkg::WinBits-1:0]    cfg_wdata_i;

  rcw_evt_if evt_if ();
  rcw_res_if res_if ();

  reno_congestion_window_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  // Window model state and configuration
  logic [rcw_pkg::DupBits-1:0] m_dup_thr;
  rcw_pkg::phase_e             m_phase;
  logic [rcw_pkg::WinBits-1:0] m_cwnd;
  logic [rcw_pkg::WinBits-1:0] m_ssth;
  logic [rcw_pkg::DupBits-1:0] m_dup;
  logic [rcw_pkg::AvdBits-1:0] m_avd;
  logic [rcw_pkg::AckBits-1:0] m_prev_ack;
  logic [rcw_pkg::WinBits-1:0] m_rwnd;

  evt_item_t        pend_q[$];
  rcw_pkg::result_t window_exp_q[$];

  int  send_gap;
  int  recv_gap;
  logic send_go;
  bit  no_idle;
  logic [rcw_pkg::AckBits-1:0] flow_ack;

  int sent_cnt, got_cnt, err_cnt;
  int rtx_seen, probe_seen, recov_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #12ms;
    $display("Some tests failed");
    $finish;
  end

  // Add with saturation at the window limit
  function automatic logic [rcw_pkg::WinBits-1:0] clamp_window_add(
      input logic [rcw_pkg::WinBits-1:0] a, input logic [rcw_pkg::WinBits-1:0] b);
    logic [rcw_pkg::WinBits:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[rcw_pkg::WinBits] ? {rcw_pkg::WinBits{1'b1}} : sum[rcw_pkg::WinBits-1:0];
  endfunction

  function automatic void reset_window_model();
    m_dup_thr  = rcw_pkg::DupThresholdRst;
    m_phase    = rcw_pkg::PhSlowStart;
    m_cwnd     = 16'd1;
    m_ssth     = rcw_pkg::InitRwndRst >> 1;
    m_dup      = '0;
    m_avd      = '0;
    m_prev_ack = '0;
    m_rwnd     = rcw_pkg::InitRwndRst;
  endfunction

  // Advance the window model by one event and return the result it gives
  function automatic rcw_pkg::result_t step_window(input evt_item_t ev);
    rcw_pkg::result_t r;
    logic    rtx;
    logic    probe;
    rtx   = 1'b0;
    probe = 1'b0;
    if (ev.op == rcw_pkg::OpTimeout) begin
      if (m_rwnd != 0) begin
        m_ssth  = clamp_window_add(m_cwnd >> 1, 16'd1);
        m_cwnd  = 16'd1;
        m_phase = rcw_pkg::PhSlowStart;
        m_dup   = '0;
        m_avd   = '0;
        rtx     = 1'b1;
      end else begin
        probe = 1'b1;
      end
    end else if (m_prev_ack == 0 || m_prev_ack != ev.ack) begin
      // new ACK
      case (m_phase)
        rcw_pkg::PhAvoidance: begin
          if (m_avd >= 2) begin
            m_cwnd = clamp_window_add(m_cwnd, 16'd1);
            m_avd  = '0;
          end else begin
            m_avd = m_avd + 1'b1;
          end
        end
        rcw_pkg::PhRecovery: begin
          m_cwnd  = m_ssth;
          m_phase = rcw_pkg::PhAvoidance;
          m_avd   = '0;
        end
        default: begin
          m_cwnd = clamp_window_add(m_cwnd, 16'd1);
          if (m_cwnd >= m_ssth) begin
            m_phase = rcw_pkg::PhAvoidance;
            m_avd   = '0;
          end
        end
      endcase
      m_dup      = '0;
      m_prev_ack = ev.ack;
      m_rwnd     = ev.adv;
    end else if (m_dup >= m_dup_thr) begin
      // duplicate at threshold: fast retransmit, receiver window kept
      if (m_phase != rcw_pkg::PhRecovery) begin
        m_ssth  = clamp_window_add(m_cwnd >> 1, 16'd1);
        m_cwnd  = clamp_window_add(m_ssth, 16'd3);
        m_phase = rcw_pkg::PhRecovery;
        m_dup   = '0;
        m_avd   = '0;
      end
      rtx = (m_rwnd != 0);
    end else begin
      // duplicate below threshold
      if (m_phase == rcw_pkg::PhRecovery) m_cwnd = clamp_window_add(m_cwnd, 16'd1);
      else if (m_dup != rcw_pkg::DupMax) m_dup = m_dup + 1'b1;
      m_avd  = '0;
      m_rwnd = ev.adv;
    end
    r.cwnd_out       = m_cwnd;
    r.ssthresh_out   = m_ssth;
    r.phase_out      = m_phase;
    r.send_allowance = (m_rwnd < m_cwnd) ? m_rwnd : m_cwnd;
    r.retransmit     = rtx;
    r.zero_win_probe = probe;
    return r;
  endfunction

  // Gap length: mostly short, a few long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [rcw_pkg::WinBits-1:0] pick_adv();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return {rcw_pkg::WinBits{1'b1}};
    if (r < 60) return 16'($urandom_range(1, 64));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic evt_item_t mk_evt(input logic op,
                                       input logic [rcw_pkg::AckBits-1:0] ack,
                                       input logic [rcw_pkg::WinBits-1:0] adv);
    evt_item_t it;
    it.op  = op;
    it.ack = ack;
    it.adv = adv;
    return it;
  endfunction

  // Register write; the model follows once the write edge has passed
  task automatic write_reg(input logic [rcw_pkg::CfgIdxBits-1:0] idx,
                           input logic [rcw_pkg::WinBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rcw_pkg::CfgDupThreshold) begin
      m_dup_thr = val[rcw_pkg::DupBits-1:0];
    end else begin
      m_rwnd = val;
      m_ssth = val >> 1;
    end
  endtask

  // Wait until every queued item went in and every result came back
  task automatic drain();
    while (pend_q.size() != 0 || window_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed ACK flow: fresh ACKs, duplicate runs, timeouts, some noise
  task automatic queue_traffic(input int n);
    int        k;
    int        run;
    int        sel;
    evt_item_t it;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        flow_ack = flow_ack + $urandom_range(1, 4000);
        pend_q.push_back(mk_evt(rcw_pkg::OpAck, flow_ack, pick_adv()));
        k++;
      end else if (sel < 80) begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        repeat (run) begin
          pend_q.push_back(mk_evt(rcw_pkg::OpAck, flow_ack, pick_adv()));
          k++;
        end
      end else if (sel < 90) begin
        pend_q.push_back(mk_evt(rcw_pkg::OpTimeout, $urandom,
                                16'($urandom_range(0, 65535))));
        k++;
      end else begin
        // arbitrary event; an ACK here also moves the flow
        it = mk_evt(1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)));
        if (it.op == rcw_pkg::OpAck) flow_ack = it.ack;
        pend_q.push_back(it);
        k++;
      end
    end
  endtask

  // Event driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_if.valid             <= 1'b0;
      evt_if.op                <= rcw_pkg::OpAck;
      evt_if.ack_number        <= '0;
      evt_if.advertised_window <= '0;
      send_gap                 = 0;
    end else begin
      if (evt_if.valid && evt_if.ready) begin
        window_exp_q.push_back(step_window(pend_q[0]));
        void'(pend_q.pop_front());
        sent_cnt++;
        send_gap = idle_len();
      end
      if (evt_if.valid && !evt_if.ready) begin
        send_go = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        send_go = 1'b0;
      end else begin
        send_go = (pend_q.size() != 0);
      end
      evt_if.valid <= send_go;
      if (send_go) begin
        evt_if.op                <= pend_q[0].op;
        evt_if.ack_number        <= pend_q[0].ack;
        evt_if.advertised_window <= pend_q[0].adv;
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    rcw_pkg::result_t got;
    rcw_pkg::result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_gap     = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.cwnd_out       = res_if.cwnd_out;
        got.ssthresh_out   = res_if.ssthresh_out;
        got.phase_out      = res_if.phase_out;
        got.send_allowance = res_if.send_allowance;
        got.retransmit     = res_if.retransmit;
        got.zero_win_probe = res_if.zero_win_probe;
        got_cnt++;
        if (got.retransmit === 1'b1) rtx_seen++;
        if (got.zero_win_probe === 1'b1) probe_seen++;
        if (got.phase_out === rcw_pkg::PhRecovery) recov_seen++;
        if (window_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] result with nothing pending: cwnd %h ssth %h", $realtime,
                     got.cwnd_out, got.ssthresh_out);
        end else begin
          want = window_exp_q.pop_front();
          if (got.cwnd_out !== want.cwnd_out || got.ssthresh_out !== want.ssthresh_out ||
              got.phase_out !== want.phase_out ||
              got.send_allowance !== want.send_allowance ||
              got.retransmit !== want.retransmit ||
              got.zero_win_probe !== want.zero_win_probe)
          begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("[%0t] mismatch on result %0d", $realtime, got_cnt);
              $display("  exp cwnd %h ssth %h phase %0d allow %h rtx %b probe %b",
                       want.cwnd_out, want.ssthresh_out, want.phase_out,
                       want.send_allowance, want.retransmit, want.zero_win_probe);
              $display("  got cwnd %h ssth %h phase %0d allow %h rtx %b probe %b",
                       got.cwnd_out, got.ssthresh_out, got.phase_out,
                       got.send_allowance, got.retransmit, got.zero_win_probe);
            end
          end
        end
        // two long hold-offs so the unit backs up and stalls its input
        if (got_cnt == 150 || got_cnt == 900) recv_gap = 240;
        else recv_gap = idle_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = rcw_pkg::CfgDupThreshold;
    cfg_wdata_i = '0;
    no_idle    = 1'b0;
    sent_cnt   = 0;
    got_cnt    = 0;
    err_cnt    = 0;
    rtx_seen   = 0;
    probe_seen = 0;
    recov_seen = 0;
    flow_ack   = $urandom_range(1, 1000);
    reset_window_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: ACK number zero twice, duplicates up to fast retransmit,
    // inflation in recovery, avoidance counting, zero window probe,
    // threshold hit with zero window, timeout with open window
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd0, 16'd16));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd0, 16'd16));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd100, 16'hFFFF));
    repeat (4) pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd100, 16'd20));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd100, 16'd20));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd200, 16'd30));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd300, 16'd30));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd400, 16'd30));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd500, 16'd30));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'hFFFF_FFFF, 16'd0));
    pend_q.push_back(mk_evt(rcw_pkg::OpTimeout, 32'hFFFF_FFFF, 16'hFFFF));
    repeat (4) pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'hFFFF_FFFF, 16'd0));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd600, 16'd40));
    pend_q.push_back(mk_evt(rcw_pkg::OpTimeout, 32'd0, 16'd0));
    pend_q.push_back(mk_evt(rcw_pkg::OpAck, 32'd700, 16'd40));
    drain();

    // Random traffic at the reset settings
    queue_traffic(350);
    drain();

    // Threshold one, widest initial window
    write_reg(rcw_pkg::CfgDupThreshold, 16'd1);
    write_reg(rcw_pkg::CfgInitRwnd, 16'hFFFF);
    queue_traffic(330);
    drain();

    // Highest threshold, closed initial window
    write_reg(rcw_pkg::CfgDupThreshold, 16'd15);
    write_reg(rcw_pkg::CfgInitRwnd, 16'd0);
    queue_traffic(330);
    drain();

    // Threshold zero: every duplicate fires fast retransmit
    write_reg(rcw_pkg::CfgDupThreshold, 16'd0);
    write_reg(rcw_pkg::CfgInitRwnd, 16'd1);
    queue_traffic(250);
    drain();

    // Mid settings, back to back without idling
    no_idle = 1'b1;
    write_reg(rcw_pkg::CfgDupThreshold, 16'd7);
    write_reg(rcw_pkg::CfgInitRwnd, 16'd1000);
    queue_traffic(370);
    drain();

    $display("Sent %0d events, checked %0d results, %0d mismatches", sent_cnt, got_cnt,
             err_cnt);
    $display("Saw %0d retransmits, %0d window probes, %0d results in fast recovery",
             rtx_seen, probe_seen, recov_seen);
    if (err_cnt == 0 && window_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
